[sv/dual_mailbox_fifo_regs_macros.svh]
// ----------------------------------------------------------------------------
// dual mailbox fifo regs: assertion macros
// shared property shorthand for the block's checkers
// ----------------------------------------------------------------------------
`ifndef DUAL_MAILBOX_FIFO_REGS_MACROS_SVH
`define DUAL_MAILBOX_FIFO_REGS_MACROS_SVH

// same-cycle implication
`define DMBX_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DMBX_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/dmbx_pkg.sv]
// ----------------------------------------------------------------------------
// dmbx_pkg
// types, codes and constants of the dual mailbox block
// ----------------------------------------------------------------------------
package dmbx_pkg;

   localparam int DATA_W         = 32;
   localparam int FIFO_DEPTH_DEF = 8;

   // command codes
   localparam logic [1:0] CMD_HOST_READ  = 2'd0;
   localparam logic [1:0] CMD_HOST_WRITE = 2'd1;
   localparam logic [1:0] CMD_PART_PUSH  = 2'd2;
   localparam logic [1:0] CMD_PART_POP   = 2'd3;

   // host register offsets
   localparam logic [5:0] OFS_READ     = 6'h00;
   localparam logic [5:0] OFS_IN_STAT  = 6'h18;
   localparam logic [5:0] OFS_WRITE    = 6'h20;
   localparam logic [5:0] OFS_OUT_STAT = 6'h38;

   // status word: full in bit 31, empty in bit 30, rest zero
   localparam int STAT_PAD_W = DATA_W - 2;

   typedef struct packed {
      logic [1:0]        cmd;
      logic [5:0]        reg_offset;
      logic [DATA_W-1:0] data_word;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic [DATA_W-1:0] popped_msg;
      logic              popped_valid;
      logic              data_irq;
      logic              access_error;
   } rsp_type;

   typedef logic [0:0] csr_type;

   typedef struct packed {
      logic accept;
      logic load;
   } ctl_cmd_type;

   typedef struct packed {
      logic out_busy;
   } dp_status_type;

endpackage

[sv/dmbx_chan_if.sv]
// ----------------------------------------------------------------------------
// dmbx_chan_if
// valid/ready channel with a typed payload
// ----------------------------------------------------------------------------
interface dmbx_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[sv/dmbx_ram.sv]
// ----------------------------------------------------------------------------
// dmbx_ram
// generic single-write single-read ram with registered read data
// ----------------------------------------------------------------------------
module dmbx_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

[sv/dmbx_ctrl.sv]
// ----------------------------------------------------------------------------
// dmbx_ctrl
// controller: takes one item, waits for the fifo read, loads the result
// ----------------------------------------------------------------------------
module dmbx_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  dmbx_pkg::dp_status_type status,
   output dmbx_pkg::ctl_cmd_type   cmd
);
   import dmbx_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_FETCH = 2'b10
   } state_type;

   state_type state_ff, state_in;

   assign req_ready  = (state_ff == ST_IDLE) && !status.out_busy;
   assign cmd.accept = req_ready && req_valid;
   assign cmd.load   = (state_ff == ST_FETCH);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.accept) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

[sv/dmbx_datapath.sv]
// ----------------------------------------------------------------------------
// dmbx_datapath
// fifo pointers, fifo rams, access decode, irq enable and result register
// ----------------------------------------------------------------------------
module dmbx_datapath #(
   parameter int FIFO_DEPTH = dmbx_pkg::FIFO_DEPTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  dmbx_pkg::ctl_cmd_type   cmd,
   output dmbx_pkg::dp_status_type status,
   input  dmbx_pkg::req_type       req,
   input  logic                    csr_wr,
   input  dmbx_pkg::csr_type       csr_data,
   output dmbx_pkg::rsp_type       rsp,
   output logic                    rsp_valid,
   input  logic                    rsp_ready
);
   import dmbx_pkg::*;

   localparam int PW = $clog2(FIFO_DEPTH);
   localparam int FW = $clog2(FIFO_DEPTH + 1);
   localparam int SW = FW + 1;

   logic [PW-1:0] in_head_ff, in_head_in, out_head_ff, out_head_in;
   logic [FW-1:0] in_fill_ff, in_fill_in, out_fill_ff, out_fill_in;
   logic [SW-1:0] in_sum, out_sum;
   logic [PW-1:0] in_tail, out_tail, in_head_nxt, out_head_nxt;
   logic          in_full, in_empty, out_full, out_empty;
   logic          in_push, in_pop, out_push, out_pop, err;
   logic [1:0]    stat;
   logic          in_pop_q_ff, out_pop_q_ff, err_q_ff;
   logic [1:0]    stat_q_ff;
   logic          irq_en_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_ff;
   logic [DATA_W-1:0] in_rdata, out_rdata;

   assign in_full   = (in_fill_ff == FW'(FIFO_DEPTH));
   assign in_empty  = (in_fill_ff == '0);
   assign out_full  = (out_fill_ff == FW'(FIFO_DEPTH));
   assign out_empty = (out_fill_ff == '0);

   // write slot: head plus fill, wrapped once
   assign in_sum  = SW'(in_head_ff) + SW'(in_fill_ff);
   assign out_sum = SW'(out_head_ff) + SW'(out_fill_ff);
   assign in_tail = (in_sum >= SW'(FIFO_DEPTH)) ? PW'(in_sum - SW'(FIFO_DEPTH))
                                                : PW'(in_sum);
   assign out_tail = (out_sum >= SW'(FIFO_DEPTH)) ? PW'(out_sum - SW'(FIFO_DEPTH))
                                                  : PW'(out_sum);

   assign in_head_nxt  = (in_head_ff == PW'(FIFO_DEPTH - 1)) ? '0 : in_head_ff + PW'(1);
   assign out_head_nxt = (out_head_ff == PW'(FIFO_DEPTH - 1)) ? '0 : out_head_ff + PW'(1);

   // access decode
   always_comb begin
      in_push  = 1'b0;
      in_pop   = 1'b0;
      out_push = 1'b0;
      out_pop  = 1'b0;
      err      = 1'b0;
      stat     = 2'b00;
      case (req.cmd)
         CMD_HOST_READ: begin
            case (req.reg_offset)
               OFS_READ: begin
                  if (in_empty) begin
                     err = 1'b1;
                  end else begin
                     in_pop = 1'b1;
                  end
               end
               OFS_IN_STAT: begin
                  stat = {in_full, in_empty};
               end
               OFS_OUT_STAT: begin
                  stat = {out_full, out_empty};
               end
               default: begin
               end
            endcase
         end
         CMD_HOST_WRITE: begin
            if (req.reg_offset == OFS_WRITE) begin
               if (out_full) begin
                  err = 1'b1;
               end else begin
                  out_push = 1'b1;
               end
            end
         end
         CMD_PART_PUSH: begin
            if (in_full) begin
               err = 1'b1;
            end else begin
               in_push = 1'b1;
            end
         end
         CMD_PART_POP: begin
            if (out_empty) begin
               err = 1'b1;
            end else begin
               out_pop = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      in_head_in  = in_head_ff;
      in_fill_in  = in_fill_ff;
      out_head_in = out_head_ff;
      out_fill_in = out_fill_ff;
      if (cmd.accept) begin
         if (in_push) begin
            in_fill_in = in_fill_ff + FW'(1);
         end
         if (in_pop) begin
            in_head_in = in_head_nxt;
            in_fill_in = in_fill_ff - FW'(1);
         end
         if (out_push) begin
            out_fill_in = out_fill_ff + FW'(1);
         end
         if (out_pop) begin
            out_head_in = out_head_nxt;
            out_fill_in = out_fill_ff - FW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_head_ff   <= '0;
         in_fill_ff   <= '0;
         out_head_ff  <= '0;
         out_fill_ff  <= '0;
         irq_en_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_head_ff  <= in_head_in;
         in_fill_ff  <= in_fill_in;
         out_head_ff <= out_head_in;
         out_fill_ff <= out_fill_in;
         if (csr_wr) begin
            irq_en_ff <= csr_data[0];
         end
         if (cmd.load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // per-item staging while the ram read completes
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         in_pop_q_ff  <= in_pop;
         out_pop_q_ff <= out_pop;
         err_q_ff     <= err;
         stat_q_ff    <= stat;
      end
      if (cmd.load) begin
         rsp_ff.read_data    <= in_pop_q_ff ? in_rdata : {stat_q_ff, STAT_PAD_W'(0)};
         rsp_ff.popped_msg   <= out_pop_q_ff ? out_rdata : '0;
         rsp_ff.popped_valid <= out_pop_q_ff;
         rsp_ff.data_irq     <= irq_en_ff && !in_empty;
         rsp_ff.access_error <= err_q_ff;
      end
   end

   dmbx_ram #(
      .WIDTH (DATA_W),
      .DEPTH (FIFO_DEPTH)
   ) u_in_ram (
      .clock   (clock),
      .wr_en   (cmd.accept && in_push),
      .wr_addr (in_tail),
      .wr_data (req.data_word),
      .rd_en   (cmd.accept && in_pop),
      .rd_addr (in_head_ff),
      .rd_data (in_rdata)
   );

   dmbx_ram #(
      .WIDTH (DATA_W),
      .DEPTH (FIFO_DEPTH)
   ) u_out_ram (
      .clock   (clock),
      .wr_en   (cmd.accept && out_push),
      .wr_addr (out_tail),
      .wr_data (req.data_word),
      .rd_en   (cmd.accept && out_pop),
      .rd_addr (out_head_ff),
      .rd_data (out_rdata)
   );

   assign status.out_busy = rsp_valid_ff && !rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp             = rsp_ff;
endmodule

[sv/dual_mailbox_fifo_regs.sv]
// ----------------------------------------------------------------------------
// dual_mailbox_fifo_regs
// two-direction mailbox: inbound fifo to the host, outbound fifo to the partner
//
// req_chan carries one access: host read or write at a register offset,
// partner push into the inbound fifo or partner pop from the outbound fifo.
// rsp_chan returns exactly one result per access: read data, popped word,
// interrupt level and an access error flag. csr_chan writes the interrupt
// enable and is always ready.
// an access is taken in its transfer cycle; the fifo ram read is registered,
// then the fetch state loads the result into the output register. the next
// access is taken at the edge where that result transfers out or later, so
// a new access is never taken before the last result has been loaded.
// reset empties both fifos and clears the interrupt enable; the fifo rams
// themselves are not cleared. while the result waits for rsp_chan.ready no
// new access is taken once the output register is occupied.
// ----------------------------------------------------------------------------
module dual_mailbox_fifo_regs #(
   parameter int FIFO_DEPTH = dmbx_pkg::FIFO_DEPTH_DEF
) (
   input logic        clock,
   input logic        reset,
   dmbx_chan_if.sink   req_chan,
   dmbx_chan_if.source rsp_chan,
   dmbx_chan_if.sink   csr_chan
);
   import dmbx_pkg::*;

   ctl_cmd_type   ctl_cmd;
   dp_status_type dp_status;
   logic          req_ready;

   dmbx_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (dp_status),
      .cmd       (ctl_cmd)
   );

   dmbx_datapath #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (ctl_cmd),
      .status    (dp_status),
      .req       (req_chan.payload),
      .csr_wr    (csr_chan.valid),
      .csr_data  (csr_chan.payload),
      .rsp       (rsp_chan.payload),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready)
   );

   assign req_chan.ready = req_ready;
   assign csr_chan.ready = 1'b1;
endmodule

[sv/dmbx_chk.sv]
// ----------------------------------------------------------------------------
// dmbx_chk
// port-level checks of the mailbox block, bound to the top level
// ----------------------------------------------------------------------------
`include "dual_mailbox_fifo_regs_macros.svh"

module dmbx_chk (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input dmbx_pkg::rsp_type rsp
);
   import dmbx_pkg::*;

   // a stalled result holds
   `DMBX_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "stalled result changed")

   // one access in flight: no transfer in the cycle after one
   `DMBX_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready, "access taken while one is in flight")

   // popped word only with a real pop
   `DMBX_ASSERT_NOW(a_pop_clean, clock, reset, rsp_valid && !rsp.popped_valid, rsp.popped_msg == '0, "popped word without pop")

   // a real pop is neither a host read nor an error
   `DMBX_ASSERT_NOW(a_pop_excl, clock, reset, rsp_valid && rsp.popped_valid, !rsp.access_error && rsp.read_data == '0, "pop result mixed with other fields")

   // failed access returns no read data
   `DMBX_ASSERT_NOW(a_err_zero, clock, reset, rsp_valid && rsp.access_error, rsp.read_data == '0, "read data on failed access")
endmodule

bind dual_mailbox_fifo_regs dmbx_chk u_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp       (rsp_chan.payload)
);
